FILE: design/assert_macros.svh
// assertion macros used by the checker file htn_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HTN_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htn assertion failed");

// next-cycle implication, disabled during reset
`define HTN_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htn assertion failed");

`endif

FILE: design/htn_pkg.sv
// types and constants of the heightmap terrain normal block
// no dependencies
package htn_pkg;

  localparam int MaxSideDef  = 256;
  localparam int NormFracDef = 14;

  // width for comparing dimension registers against the side limit
  localparam int CMP_W = 13;
  // width of a dimension register
  localparam int DIM_W = 9;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd2;
  // width of the texcoord dividend
  localparam int NUM_W = 24;
  // width of the squared normal length
  localparam int LEN_W = 23;

  // height / 15 by reciprocal: floor(x * RECIP / 2^SHIFT)
  localparam logic [20:0] HF_RECIP = 21'd1118482;
  localparam int HF_SHIFT = 24;
  localparam logic [18:0] HF_ROUND = 19'd7;

  // y component of every face normal
  localparam logic signed [7:0] Y_UNIT = 8'sd15;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } htn_cmd_e;

  typedef enum logic {
    REG_GRID_WIDTH = 1'b0,
    REG_GRID_DEPTH = 1'b1
  } htn_reg_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [31:0] pixel_word;
  } htn_in_t;

  typedef struct packed {
    logic [7:0]         pos_x;
    logic [7:0]         pos_z;
    logic [15:0]        height_fixed;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } htn_out_t;

  // per-vertex normal sum as kept in memory
  typedef struct packed {
    logic signed [11:0] x;
    logic signed [7:0]  y;
    logic signed [11:0] z;
  } htn_sum_t;

endpackage

FILE: design/heightmap_terrain_normals.sv
// heightmap terrain vertex block: height load, normal build, vertex read
// depends on htn_pkg and htn_ram
// load: written to the height memory when accepted. read: a bit-serial normalize
// search (square, low and high product per bit), then the 24-step texcoord divider.
// build: clears the sum memory, then per quad 4 height reads and 6 read-modify-writes
// of the sum memory. after reset the sum memory is cleared with busy high; results
// cannot be stalled.
module heightmap_terrain_normals #(
  parameter int MAX_SIDE         = htn_pkg::MaxSideDef,
  parameter int NORMAL_FRAC_BITS = htn_pkg::NormFracDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  htn_pkg::htn_in_t             in_i,
  output logic                         done_o,
  output htn_pkg::htn_out_t            result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [htn_pkg::DIM_W-1:0]    cfg_data_i
);
  import htn_pkg::*;

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIDE + 1);
  localparam int F     = NORMAL_FRAC_BITS;
  localparam int QW    = F + 1;
  localparam int TW    = F + 2;
  localparam int SQW   = 2 * TW;
  localparam int HALF  = (SQW + 1) / 2;
  localparam int HIW   = SQW - HALF;
  localparam int PLW   = HALF + LEN_W;
  localparam int PHW   = HIW + LEN_W;
  localparam int CMPW  = SQW + LEN_W;
  localparam int BW    = $clog2(F + 1);
  localparam int DCW   = $clog2(NUM_W + 1);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_HRD   = 13'b0000000000100,
    ST_SRD   = 13'b0000000001000,
    ST_SWR   = 13'b0000000010000,
    ST_RD    = 13'b0000000100000,
    ST_SQR   = 13'b0000001000000,
    ST_LEN   = 13'b0000010000000,
    ST_MSQ   = 13'b0000100000000,
    ST_MLO   = 13'b0001000000000,
    ST_MHI   = 13'b0010000000000,
    ST_DIV   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_e;

  function automatic logic [CW-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    if (vx == '0) return CW'(1);
    else if (vx > CMP_W'(MAX_SIDE)) return CW'(MAX_SIDE);
    else return CW'(vx);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] r, input logic [CW-1:0] c);
    logic [AW:0] full;
    full = (AW+1)'(r) * (AW+1)'(MAX_SIDE) + (AW+1)'(c);
    return full[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0]    clr_q;
  logic             bld_q;
  logic [DIM_W-1:0] wdim_q, ddim_q;
  logic [CW-1:0]    qr_q, qc_q;
  logic [2:0]       hidx_q;
  logic [2:0]       k_q;
  logic [BW-1:0]    bit_q;
  logic [DCW-1:0]   dcnt_q;

  // payload registers
  logic [7:0]              row_q, col_q;
  logic [7:0]              h_q [4];
  logic [7:0]              hgt_q;
  logic [39:0]             hprod_q;
  logic signed [11:0]      s_q [3];
  logic [21:0]             sqs_q [3];
  logic [LEN_W-1:0]        len2_q;
  logic [CMPW-1:0]         rhs_q [3];
  logic [QW-1:0]           q_q [3];
  logic [SQW-1:0]          sq_q [3];
  logic [PLW-1:0]          plo_q [3];
  logic [NUM_W-1:0]        num_q [2];
  logic [CW+1:0]           rem_q [2];
  logic [NUM_W-1:0]        quo_q [2];

  logic [CW-1:0] weff, deff;
  logic          accept, in_grid;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] qa [4];
  logic [AW-1:0] step_addr;

  logic          h_we, s_we;
  logic [AW-1:0] h_raddr, s_raddr, s_waddr;
  logic [7:0]    h_rdata;
  logic [31:0]   s_rdata, s_wdata;
  htn_sum_t      cur_sum, upd_sum;
  logic [11:0]   fx, fz;

  logic [QW-1:0]   cand [3];
  logic [TW-1:0]   tval [3];
  logic [PHW-1:0]  phi [3];
  logic [CMPW-1:0] lhs [3];
  logic [CW-1:0]   den [2];
  logic [7:0]      tidx [2];
  logic [CW+1:0]   rem_sh [2];
  logic            qbit [2];
  logic [14:0]     mag [3];
  logic [15:0]     nrm [3];

  assign weff        = eff_dim(wdim_q);
  assign deff        = eff_dim(ddim_q);
  assign accept      = start && !busy;
  assign in_grid     = (CMP_W'(in_i.row) < CMP_W'(deff)) && (CMP_W'(in_i.col) < CMP_W'(weff));
  assign in_addr     = addr_of(CW'(in_i.row), CW'(in_i.col));
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // quad corner addresses
  assign qa[0] = addr_of(CW'(qr_q + CW'(1)), qc_q);
  assign qa[1] = addr_of(CW'(qr_q + CW'(1)), CW'(qc_q + CW'(1)));
  assign qa[2] = addr_of(qr_q, CW'(qc_q + CW'(1)));
  assign qa[3] = addr_of(qr_q, qc_q);

  // vertex touched by the current face add
  always_comb begin
    unique case (k_q)
      3'd0:    step_addr = qa[0];
      3'd1:    step_addr = qa[1];
      3'd2:    step_addr = qa[2];
      3'd3:    step_addr = qa[0];
      3'd4:    step_addr = qa[2];
      default: step_addr = qa[3];
    endcase
  end

  // face normal of the current add
  always_comb begin
    if (k_q < 3'd3) begin
      fx = {4'b0, h_q[0]} - {4'b0, h_q[1]};
      fz = {4'b0, h_q[2]} - {4'b0, h_q[1]};
    end else begin
      fx = {4'b0, h_q[3]} - {4'b0, h_q[2]};
      fz = {4'b0, h_q[3]} - {4'b0, h_q[0]};
    end
    cur_sum   = htn_sum_t'(s_rdata);
    upd_sum.x = cur_sum.x + $signed(fx);
    upd_sum.y = cur_sum.y + Y_UNIT;
    upd_sum.z = cur_sum.z + $signed(fz);
  end

  // memory port control
  always_comb begin
    h_we    = accept && (in_i.cmd == CMD_LOAD) && in_grid;
    h_raddr = in_addr;
    s_we    = 1'b0;
    s_waddr = clr_q;
    s_wdata = '0;
    s_raddr = in_addr;
    if (state_q == ST_HRD) begin
      h_raddr = qa[hidx_q[1:0]];
    end
    if (state_q == ST_CLEAR) begin
      s_we = 1'b1;
    end
    if (state_q == ST_SRD) begin
      s_raddr = step_addr;
    end
    if (state_q == ST_SWR) begin
      s_we    = 1'b1;
      s_waddr = step_addr;
      s_wdata = 32'(upd_sum);
    end
  end

  htn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (in_addr),
    .wdata_i (in_i.pixel_word[7:0]),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  htn_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // normalize search trial and divider step, per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = q_q[i] | (QW'(1) << bit_q);
      tval[i] = {cand[i], 1'b0} - TW'(1);
      phi[i]  = PHW'(sq_q[i][SQW-1:HALF]) * PHW'(len2_q);
      lhs[i]  = (CMPW'(phi[i]) << HALF) + CMPW'(plo_q[i]);
    end
    tidx[0] = col_q;
    tidx[1] = row_q;
    den[0]  = weff - CW'(1);
    den[1]  = deff - CW'(1);
    for (int j = 0; j < 2; j++) begin
      rem_sh[j] = {rem_q[j][CW:0], num_q[j][NUM_W-1]};
      qbit[j]   = (rem_sh[j] >= (CW+2)'({den[j], 1'b0}));
    end
  end

  // state and control counters
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = (bld_q && weff > CW'(1) && deff > CW'(1)) ? ST_HRD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_i.cmd == CMD_BUILD) state_d = ST_CLEAR;
          else if (in_i.cmd == CMD_READ && in_grid) state_d = ST_RD;
        end
      end
      ST_HRD:  if (hidx_q == 3'd4) state_d = ST_SRD;
      ST_SRD:  state_d = ST_SWR;
      ST_SWR: begin
        if (k_q != 3'd5) state_d = ST_SRD;
        else if ((CW+1)'(qc_q) + (CW+1)'(2) < (CW+1)'(weff)) state_d = ST_HRD;
        else if ((CW+1)'(qr_q) + (CW+1)'(2) < (CW+1)'(deff)) state_d = ST_HRD;
        else state_d = ST_IDLE;
      end
      ST_RD:   state_d = ST_SQR;
      ST_SQR:  state_d = ST_LEN;
      ST_LEN:  state_d = ST_MSQ;
      ST_MSQ:  state_d = ST_MLO;
      ST_MLO:  state_d = ST_MHI;
      ST_MHI:  state_d = (bit_q == '0) ? ST_DIV : ST_MSQ;
      ST_DIV:  if (dcnt_q == DCW'(NUM_W - 1)) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      bld_q   <= 1'b0;
      wdim_q  <= DIM_RESET;
      ddim_q  <= DIM_RESET;
      qr_q    <= '0;
      qc_q    <= '0;
      hidx_q  <= '0;
      k_q     <= '0;
      bit_q   <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_valid_i) begin
        unique case (htn_reg_e'(cfg_index_i))
          REG_GRID_WIDTH: wdim_q <= cfg_data_i;
          REG_GRID_DEPTH: ddim_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_CLEAR: begin
          qr_q   <= '0;
          qc_q   <= '0;
          hidx_q <= '0;
          if (clr_q == AW'(DEPTH - 1)) begin
            clr_q <= '0;
            bld_q <= 1'b0;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start && in_i.cmd == CMD_BUILD) bld_q <= 1'b1;
        end
        ST_HRD: begin
          hidx_q <= hidx_q + 3'd1;
          k_q    <= '0;
        end
        ST_SWR: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd5) begin
            hidx_q <= '0;
            if ((CW+1)'(qc_q) + (CW+1)'(2) < (CW+1)'(weff)) begin
              qc_q <= qc_q + CW'(1);
            end else begin
              qc_q <= '0;
              qr_q <= qr_q + CW'(1);
            end
          end
        end
        ST_LEN:  bit_q <= BW'(F);
        ST_MHI: begin
          bit_q  <= bit_q - BW'(1);
          dcnt_q <= '0;
        end
        ST_DIV:  dcnt_q <= dcnt_q + DCW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q <= in_i.row;
      col_q <= in_i.col;
    end
    if (state_q == ST_HRD && hidx_q != 3'd0) begin
      h_q[2'(hidx_q - 3'd1)] <= h_rdata;
    end
    if (state_q == ST_RD) begin
      hgt_q  <= h_rdata;
      s_q[0] <= cur_sum.x;
      s_q[1] <= 12'(cur_sum.y);
      s_q[2] <= cur_sum.z;
    end
    // squares and height scaling
    if (state_q == ST_SQR) begin
      for (int i = 0; i < 3; i++) begin
        sqs_q[i] <= 22'(24'(s_q[i] * s_q[i]));
      end
      hprod_q <= 40'({hgt_q, 11'b0} + HF_ROUND) * 40'(HF_RECIP);
    end
    // length, search start, divider load
    if (state_q == ST_LEN) begin
      len2_q <= LEN_W'(sqs_q[0]) + LEN_W'(sqs_q[1]) + LEN_W'(sqs_q[2]);
      for (int i = 0; i < 3; i++) begin
        rhs_q[i] <= CMPW'(sqs_q[i]) << (2 * F + 2);
        q_q[i]   <= '0;
      end
      for (int j = 0; j < 2; j++) begin
        num_q[j] <= NUM_W'({tidx[j], 16'h0000}) + NUM_W'(den[j]);
        rem_q[j] <= '0;
        quo_q[j] <= '0;
      end
    end
    if (state_q == ST_MSQ) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= tval[i] * tval[i];
    end
    if (state_q == ST_MLO) begin
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= PLW'(sq_q[i][HALF-1:0]) * PLW'(len2_q);
      end
    end
    if (state_q == ST_MHI) begin
      for (int i = 0; i < 3; i++) begin
        if (lhs[i] <= rhs_q[i]) q_q[i] <= cand[i];
      end
    end
    // restoring divider step, one quotient bit per cycle
    if (state_q == ST_DIV) begin
      for (int j = 0; j < 2; j++) begin
        rem_q[j] <= qbit[j] ? rem_sh[j] - (CW+2)'({den[j], 1'b0}) : rem_sh[j];
        num_q[j] <= num_q[j] << 1;
        quo_q[j] <= {quo_q[j][NUM_W-2:0], qbit[j]};
      end
    end
  end

  // result assembly
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = (32'(q_q[i]) > 32'd32767) ? 15'h7fff : 15'(q_q[i]);
      if (s_q[i] == '0) nrm[i] = '0;
      else if (s_q[i][11]) nrm[i] = -{1'b0, mag[i]};
      else nrm[i] = {1'b0, mag[i]};
    end
    result_o.pos_x        = col_q;
    result_o.pos_z        = row_q;
    result_o.height_fixed = hprod_q[HF_SHIFT +: 16];
    result_o.normal_x     = nrm[0];
    result_o.normal_y     = nrm[1];
    result_o.normal_z     = nrm[2];
    result_o.tex_u        = (den[0] == '0) ? 16'h0000 : quo_q[0][15:0];
    result_o.tex_v        = (den[1] == '0) ? 16'h0000 : quo_q[1][15:0];
  end

  assign done_o = (state_q == ST_OUT);

endmodule

FILE: design/htn_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module htn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/htn_checker.sv
// port-level checks of the heightmap terrain normal block, bound to the top
// depends on htn_pkg and assert_macros.svh
`include "assert_macros.svh"

module htn_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input htn_pkg::htn_in_t in_i,
  input logic             done_o
);
  import htn_pkg::*;

  logic acc_build, acc_load;

  assign acc_build = start && !busy && (in_i.cmd == CMD_BUILD);
  assign acc_load  = start && !busy && (in_i.cmd == CMD_LOAD);

  // a build transaction always occupies the block
  `HTN_ASSERT_NXT(a_build_busy, clk_i, rst_ni, acc_build, busy)
  // a load transaction completes in its own cycle with no result
  `HTN_ASSERT_NXT(a_load_free, clk_i, rst_ni, acc_load, !busy && !done_o)
  // a result is a single-cycle strobe
  `HTN_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  // the block frees up right after its result
  `HTN_ASSERT_NXT(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // a result only comes while the block is busy
  `HTN_ASSERT_NOW(a_done_busy, clk_i, rst_ni, done_o, busy)

endmodule

bind heightmap_terrain_normals htn_checker u_htn_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .in_i   (in_i),
  .done_o (done_o)
);
